@@ design/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SVT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SVT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/svt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

  // request actions
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // entry count updates
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // memory write selects
  localparam logic [1:0] WR_NONE      = 2'd0;
  localparam logic [1:0] WR_DATA_IDX  = 2'd1;
  localparam logic [1:0] WR_DATA_PREV = 2'd2;
  localparam logic [1:0] WR_VAL_IDX   = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_empty;
    logic [4:0] entry_count;
  } out_res_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       rd_prev;
    logic [1:0] wr_sel;
    logic       idx_inc;
    logic       idx_dec;
    logic       set_found;
    logic       res_load;
    logic [1:0] cnt_op;
    logic [1:0] status;
  } svt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_cnt;
    logic rd_less;
    logic rd_equal;
    logic found;
  } svt_stat_t;

endpackage

`default_nettype wire

@@ design/svt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svt_datapath import svt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_req_t   in_req,
  input  wire svt_cmd_t  cmd,
  output svt_stat_t      stat,
  output out_res_t       out_res
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0]        mem [TABLE_DEPTH];
  logic [31:0]        rdata_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [CW-1:0]      idx_prev;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  out_res_t           res_r;

  assign idx_prev = idx_r - CW'(1);

  // scan index, hit flag and entry count
  always_comb begin
    idx_nxt   = idx_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    if (cmd.load) begin
      idx_nxt   = (in_req.action == ACT_INSERT) ? cnt_r : '0;
      found_nxt = 1'b0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_prev;
    end
    if (cmd.set_found) begin
      found_nxt = 1'b1;
    end
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + CW'(1);
      CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // request value
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_req.value;
    end
  end

  // write port address and data
  always_comb begin
    case (cmd.wr_sel)
      WR_DATA_PREV: begin
        waddr = idx_prev[AW-1:0];
        wdata = rdata_r;
      end
      WR_VAL_IDX: begin
        waddr = idx_r[AW-1:0];
        wdata = val_r;
      end
      default: begin
        waddr = idx_r[AW-1:0];
        wdata = rdata_r;
      end
    endcase
  end

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_prev ? idx_prev[AW-1:0] : idx_r[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.status      <= cmd.status;
      res_r.is_empty    <= (cnt_nxt == '0);
      res_r.entry_count <= 5'(cnt_nxt);
    end
  end

  assign out_res = res_r;

  // flags for the controller
  assign stat.full       = (cnt_r == CW'(TABLE_DEPTH));
  assign stat.idx_zero   = (idx_r == '0);
  assign stat.idx_at_cnt = (idx_r == cnt_r);
  assign stat.rd_less    = ($signed(rdata_r) < val_r);
  assign stat.rd_equal   = (rdata_r == val_r);
  assign stat.found      = found_r;

endmodule

`default_nettype wire

@@ design/svt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svt_ctrl import svt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  [1:0] in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire svt_stat_t stat,
  output svt_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] act_r, act_nxt;
  logic [1:0] st_r, st_nxt;
  logic [1:0] cop_r, cop_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencing of the table scan
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    st_nxt    = st_r;
    cop_nxt   = cop_r;
    cmd       = '0;
    cmd.wr_sel = WR_NONE;
    cmd.cnt_op = CNT_HOLD;
    cmd.status = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          act_nxt  = in_action;
          st_nxt   = ST_OK;
          cop_nxt  = CNT_HOLD;
          case (in_action)
            ACT_CLEAR: begin
              cop_nxt   = CNT_CLR;
              state_nxt = S_FINISH;
            end
            ACT_INSERT: begin
              if (stat.full) begin
                st_nxt    = ST_FULL;
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_READ;
          endcase
        end
      end
      S_READ: begin
        if (act_r == ACT_INSERT) begin
          // walk down from the top, stop at the bottom
          if (stat.idx_zero) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
            state_nxt   = S_EVAL;
          end
        end else if (stat.idx_at_cnt) begin
          // end of the stored entries
          if ((act_r == ACT_REMOVE) && stat.found) begin
            st_nxt  = ST_OK;
            cop_nxt = CNT_DEC;
          end else begin
            st_nxt = ST_MISS;
          end
          state_nxt = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (act_r)
          ACT_INSERT: begin
            if (stat.rd_less) begin
              state_nxt = S_PLACE;
            end else begin
              // move the entry up one slot
              cmd.wr_sel  = WR_DATA_IDX;
              cmd.idx_dec = 1'b1;
              state_nxt   = S_READ;
            end
          end
          ACT_SEARCH: begin
            if (stat.rd_equal) begin
              st_nxt    = ST_OK;
              state_nxt = S_FINISH;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_READ;
            end
          end
          default: begin
            // remove: mark the first hit, then close the gap behind it
            if (!stat.found) begin
              cmd.set_found = stat.rd_equal;
            end else begin
              cmd.wr_sel = WR_DATA_PREV;
            end
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        endcase
      end
      S_PLACE: begin
        cmd.wr_sel = WR_VAL_IDX;
        st_nxt     = ST_OK;
        cop_nxt    = CNT_INC;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.cnt_op   = cop_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_INSERT;
      st_r        <= ST_OK;
      cop_r       <= CNT_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      st_r        <= st_nxt;
      cop_r       <= cop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/sorted_value_table_unit.sv @@
// Sorted value table: holds up to TABLE_DEPTH signed 32-bit values in ascending
// order in a single-port-style entry memory (one write, one registered read per
// cycle). Each request is insert, search, remove-first-equal or clear; each
// gives one result with status, empty flag and entry count (low 5 bits). The
// table is scanned by a controller one entry at a time, a memory read (S_READ)
// then a compare (S_EVAL). Clear and insert into a full table do not scan;
// remove and a search that misses scan every stored entry; a search that hits
// stops on the matching entry; insert walks down from the top over the stored
// entries not less than the new value, shifting each up one slot, and stops at
// a smaller entry or at the bottom before it places the value. The last cycle
// of a request stretches while the previous result is still waiting for
// out_ready. One request is in progress at a time; a finished result waits in
// the output register while the next request is accepted. Entries are not
// cleared at reset, only the count, scan index and hit flag are.
`timescale 1ns / 1ps
`default_nettype none

module sorted_value_table_unit import svt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_req,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_res_t     out_res
);

`include "assert_macros.svh"

  svt_cmd_t  cmd;
  svt_stat_t stat;

  // sequencer
  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_req.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry memory, count and result register
  svt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

  // checks
  `SVT_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request overlap")
  `SVT_ASSERT_NOW(a_empty_count, out_valid && out_res.is_empty, out_res.entry_count == 5'd0, "empty with nonzero count")
  `SVT_ASSERT_NOW(a_full_count, out_valid && (out_res.status == ST_FULL), out_res.entry_count == 5'(TABLE_DEPTH), "full status with wrong count")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import svt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  // cycles with no handshake on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // longest request is a remove over a full table or an insert into a nearly full one, well under this
  localparam int SETTLE_CYCLES = 64;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  out_res_t out_res;

  bit                 idling_on = 1'b1;
  int                 mismatch_count = 0;
  logic signed [31:0] shadow_entries[$];
  out_res_t           pending_results[$];

  sorted_value_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow table: apply one request and work out its result
  function automatic out_res_t predict_table_step(input in_req_t req);
    out_res_t           res;
    int                 pos;
    logic signed [31:0] v;
    v = req.value;
    pos = 0;
    res.status = ST_OK;
    case (req.action)
      ACT_INSERT: begin
        if (shadow_entries.size() >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // ahead of the first entry not less than the new value
          while (pos < shadow_entries.size() && shadow_entries[pos] < v) pos++;
          shadow_entries.insert(pos, v);
        end
      end
      ACT_SEARCH: begin
        res.status = ST_MISS;
        foreach (shadow_entries[k]) begin
          if (shadow_entries[k] == v) res.status = ST_OK;
        end
      end
      ACT_REMOVE: begin
        while (pos < shadow_entries.size() && shadow_entries[pos] != v) pos++;
        if (pos >= shadow_entries.size()) begin
          res.status = ST_MISS;
        end else begin
          shadow_entries.delete(pos);
        end
      end
      default: begin
        shadow_entries.delete();
      end
    endcase
    res.is_empty = (shadow_entries.size() == 0);
    res.entry_count = 5'(shadow_entries.size());
    return res;
  endfunction

  // mostly a small pool so that searches and removes hit, plus extremes and full range
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      return $signed($urandom_range(0, 11)) - 6;
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end else begin
      return $urandom();
    end
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ACT_INSERT;
    else if (r < 70) return ACT_SEARCH;
    else if (r < 96) return ACT_REMOVE;
    else return ACT_CLEAR;
  endfunction

  // drive one request, optionally after an idle burst, and wait for acceptance
  task automatic send_request(input logic [1:0] action, input logic signed [31:0] value);
    in_req_t req;
    int      gap;
    req.action = action;
    req.value = value;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_table_step(req));
  endtask

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: status %0d empty %0d count %0d",
                   out_res.status, out_res.is_empty, out_res.entry_count);
        end
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res.status !== exp_res.status || out_res.is_empty !== exp_res.is_empty ||
            out_res.entry_count !== exp_res.entry_count) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected status %0d empty %0d count %0d, got %0d %0d %0d",
                     exp_res.status, exp_res.is_empty, exp_res.entry_count,
                     out_res.status, out_res.is_empty, out_res.entry_count);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // actions on an empty table
  task automatic test_empty_table();
    send_request(ACT_CLEAR, VAL_MAX);
    send_request(ACT_SEARCH, 32'sd0);
    send_request(ACT_REMOVE, VAL_MIN);
  endtask

  // extreme values, duplicates, hits and misses
  task automatic test_value_extremes();
    send_request(ACT_INSERT, VAL_MAX);
    send_request(ACT_INSERT, VAL_MIN);
    send_request(ACT_INSERT, 32'sd0);
    send_request(ACT_INSERT, -32'sd1);
    send_request(ACT_INSERT, VAL_MAX);
    send_request(ACT_SEARCH, VAL_MIN);
    send_request(ACT_SEARCH, 32'sd1);
    send_request(ACT_REMOVE, VAL_MAX);
    send_request(ACT_REMOVE, 32'sd5);
    send_request(ACT_SEARCH, VAL_MAX);
  endtask

  // fill to capacity, insert into a full table, search, then clear
  task automatic test_full_table();
    int i;
    i = 0;
    while (shadow_entries.size() < TABLE_DEPTH) begin
      send_request(ACT_INSERT, 32'sd100 - 32'(i * 13));
      i++;
    end
    send_request(ACT_INSERT, 32'sd7);
    send_request(ACT_SEARCH, 32'sd100);
    send_request(ACT_CLEAR, 32'sd0);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_request(pick_action(), pick_value());
  endtask

  // grow to full then shrink to empty by removing stored values, with an extra request at each end
  task automatic test_fill_and_drain(input int rounds);
    int idx;
    repeat (rounds) begin
      while (shadow_entries.size() < TABLE_DEPTH) send_request(ACT_INSERT, pick_value());
      send_request(ACT_INSERT, pick_value());
      while (shadow_entries.size() > 0) begin
        idx = $urandom_range(0, shadow_entries.size() - 1);
        send_request(ACT_REMOVE, shadow_entries[idx]);
      end
      send_request(ACT_REMOVE, pick_value());
      send_request(ACT_SEARCH, pick_value());
    end
  endtask

  // sender holds off until every outstanding result has come back
  task automatic test_paused_sender();
    repeat (20) send_request(pick_action(), pick_value());
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) send_request(pick_action(), pick_value());
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) send_request(pick_action(), pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_value_extremes();
    test_full_table();
    test_random_mix(360);
    test_fill_and_drain(2);
    test_paused_sender();
    test_back_to_back(120);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
